@@ rtl/fourier_series_point_evaluator_unit_defines.svh @@
// Assertion macros for the Fourier series point evaluator.
`ifndef FOURIER_SERIES_POINT_EVALUATOR_UNIT_DEFINES_SVH
`define FOURIER_SERIES_POINT_EVALUATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FSPE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FSPE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define FSPE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define FSPE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

@@ rtl/fspe_pkg.sv @@
package fspe_pkg;

  localparam int IN_DATA_W  = 208;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int CNT_REG_W  = 5;
  localparam int SIZE_REG_W = 6;
  localparam int IDX_W      = 12;
  localparam int WORD_W     = 32;
  localparam int OUT_W      = 48;
  localparam int SC_W       = 18;
  localparam int CRD_W      = 34;
  localparam int ACC_W      = 64;

  localparam logic [1:0] REQ_COEF = 2'd0;
  localparam logic [1:0] REQ_WAVE = 2'd1;
  localparam logic [1:0] REQ_EVAL = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd5;

  // round(2^32 / (2*pi))
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_t;

  typedef struct packed {
    logic load_coef;
    logic load_wave;
    logic start;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_term;
    logic empty_series;
    logic busy;
  } sts_t;

  // arctan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] v;
    begin
      case (i)
        0:  v = 32'h20000000;
        1:  v = 32'h12E4051D;
        2:  v = 32'h09FB385B;
        3:  v = 32'h051111D4;
        4:  v = 32'h028B0D43;
        5:  v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;
        7:  v = 32'h00517C55;
        8:  v = 32'h0028BE53;
        9:  v = 32'h00145F2E;
        10: v = 32'h000A2F98;
        11: v = 32'h000517CC;
        12: v = 32'h00028BE6;
        13: v = 32'h000145F3;
        14: v = 32'h0000A2F9;
        15: v = 32'h0000517C;
        16: v = 32'h000028BE;
        17: v = 32'h0000145F;
        18: v = 32'h00000A2F;
        19: v = 32'h00000517;
        20: v = 32'h0000028B;
        21: v = 32'h00000145;
        22: v = 32'h000000A2;
        23: v = 32'h00000051;
        24: v = 32'h00000028;
        25: v = 32'h00000014;
        26: v = 32'h0000000A;
        27: v = 32'h00000005;
        28: v = 32'h00000002;
        29: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

@@ rtl/fspe_ram.sv @@
module fspe_ram #(
  parameter int W = 32,
  parameter int D = 32,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fspe_ctrl.sv @@
module fspe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [1:0]      in_req,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  fspe_pkg::sts_t  sts,
  output fspe_pkg::cmd_t  cmd,
  output fspe_pkg::state_t state
);
  import fspe_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_req)
            REQ_COEF: cmd.load_coef = 1'b1;
            REQ_WAVE: cmd.load_wave = 1'b1;
            REQ_EVAL: begin
              cmd.start = 1'b1;
              state_nxt = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (sts.empty_series) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          if (sts.last_term) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // previous result must be gone before the output register reloads
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

@@ rtl/fspe_datapath.sv @@
module fspe_datapath #(
  parameter int MAX_PER_AXIS = 16,
  parameter int MAX_TABLE    = 32,
  parameter int MAX_COEFS    = 4096,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fspe_pkg::cmd_t                         cmd,
  output fspe_pkg::sts_t                         sts,
  input  logic                                   cfg_valid,
  input  logic [fspe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [fspe_pkg::IDX_W-1:0]             entry_index,
  input  logic [1:0]                             axis_sel,
  input  logic [fspe_pkg::WORD_W-1:0]            coef_real,
  input  logic [fspe_pkg::WORD_W-1:0]            coef_imag,
  input  logic [fspe_pkg::WORD_W-1:0]            wave_value,
  input  logic signed [fspe_pkg::WORD_W-1:0]     pos_x,
  input  logic signed [fspe_pkg::WORD_W-1:0]     pos_y,
  input  logic signed [fspe_pkg::WORD_W-1:0]     pos_z,
  output logic [fspe_pkg::OUT_W-1:0]             potential_real,
  output logic [fspe_pkg::OUT_W-1:0]             potential_imag,
  output logic                                   saturated
);
  import fspe_pkg::*;

  localparam int CW  = $clog2(MAX_PER_AXIS + 1);
  localparam int TCW = 3 * CW;
  localparam int IXW = ((CW > 8) ? CW : 8) + 2;
  localparam int TAW = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
  localparam int CAW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int S   = CORDIC_STEPS;
  localparam int NST = S + 9;

  function automatic logic signed [SC_W-1:0] sc_round(input logic signed [CRD_W-1:0] v,
                                                      input logic flip);
    logic signed [CRD_W:0] r;
    begin
      r = $signed({v[CRD_W-1], v}) + 35'sd4096;
      r = r >>> 13;
      if (flip) begin
        r = -r;
      end
      if (r > 35'sd131071) begin
        return 18'sd131071;
      end else if (r < -35'sd131072) begin
        return -18'sd131072;
      end
      return r[SC_W-1:0];
    end
  endfunction

  // configuration
  logic [CNT_REG_W-1:0]  cnt_r  [3];
  logic [SIZE_REG_W-1:0] size_r [3];

  // term sequencer
  logic [CW-1:0]         cnt_eff [3];
  logic [CW-1:0]         g_r     [3];
  logic                  at_end  [3];
  logic signed [IXW-1:0] tidx    [3];
  logic [2:0]            tok;
  logic [TCW-1:0]        ci_r;
  logic [31:0]           ci_w;
  logic [31:0]           idx_w;
  logic                  cok;

  // memories
  logic [WORD_W-1:0] cre_rd, cim_rd;
  logic [WORD_W-1:0] wave_rd [3];
  logic              wave_we [3];
  logic              coef_we;

  // pipeline
  logic [NST-1:0]            vld_r;
  logic                      cok1_r;
  logic [2:0]                tok1_r;
  logic signed [WORD_W-1:0]  pos_r [3];
  logic signed [63:0]        ph_r  [3];
  logic [63:0]               phs_r;
  logic [61:0]               mhi_full, mlo_full;
  logic [31:0]               mhi_r;
  logic [29:0]               mlo_r;
  logic [31:0]               t_r;
  logic [31:0]               tz;
  logic                      flip;
  logic signed [WORD_W-1:0]  cre_d [0:S+5];
  logic signed [WORD_W-1:0]  cim_d [0:S+5];
  logic signed [CRD_W-1:0]   cx_r  [0:S];
  logic signed [CRD_W-1:0]   cy_r  [0:S];
  logic signed [CRD_W-1:0]   cz_r  [0:S];
  logic                      flip_d [0:S];
  logic signed [SC_W-1:0]    cos_r, sin_r;
  logic signed [49:0]        p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic signed [50:0]        tr_r, ti_r;
  logic signed [ACC_W-1:0]   acc_re_r, acc_im_r;
  logic signed [ACC_W:0]     sum_re, sum_im;
  logic                      sat_r;

  // result rounding
  logic signed [OUT_W:0]     rnd_re, rnd_im;
  logic                      clip_re, clip_im;
  logic [OUT_W-1:0]          pot_re_r, pot_im_r;
  logic                      sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        cnt_r[a]  <= CNT_REG_W'(1);
        size_r[a] <= SIZE_REG_W'(1);
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT_X: cnt_r[0]  <= cfg_data[CNT_REG_W-1:0];
        CFG_COUNT_Y: cnt_r[1]  <= cfg_data[CNT_REG_W-1:0];
        CFG_COUNT_Z: cnt_r[2]  <= cfg_data[CNT_REG_W-1:0];
        CFG_SIZE_X:  size_r[0] <= cfg_data;
        CFG_SIZE_Y:  size_r[1] <= cfg_data;
        CFG_SIZE_Z:  size_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (32'(cnt_r[a]) > MAX_PER_AXIS) begin
        cnt_eff[a] = CW'(MAX_PER_AXIS);
      end else begin
        cnt_eff[a] = CW'(cnt_r[a]);
      end
      // centred table entry: size/2 - count/2 + g
      tidx[a]   = IXW'(size_r[a] >> 1) - IXW'(cnt_eff[a] >> 1) + IXW'(g_r[a]);
      tok[a]    = !tidx[a][IXW-1] && (int'(tidx[a]) < MAX_TABLE);
      at_end[a] = (g_r[a] == cnt_eff[a] - 1'b1);
    end
  end

  // coefficient index gz + cz*gy + cy*cz*gx advances by one per term
  assign ci_w = 32'(ci_r);
  assign cok  = ci_w < MAX_COEFS;

  assign sts.last_term    = at_end[0] && at_end[1] && at_end[2];
  assign sts.empty_series = (cnt_eff[0] == '0) || (cnt_eff[1] == '0) || (cnt_eff[2] == '0);
  assign sts.busy         = |vld_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int a = 0; a < 3; a++) begin
        g_r[a] <= '0;
      end
      ci_r     <= '0;
      pos_r[0] <= pos_x;
      pos_r[1] <= pos_y;
      pos_r[2] <= pos_z;
    end else if (cmd.issue) begin
      ci_r   <= ci_r + 1'b1;
      g_r[2] <= at_end[2] ? '0 : g_r[2] + 1'b1;
      if (at_end[2]) begin
        g_r[1] <= at_end[1] ? '0 : g_r[1] + 1'b1;
        if (at_end[1]) begin
          g_r[0] <= at_end[0] ? '0 : g_r[0] + 1'b1;
        end
      end
    end
  end

  assign idx_w   = 32'(entry_index);
  assign coef_we = cmd.load_coef && (idx_w < MAX_COEFS);

  fspe_ram #(.W(WORD_W), .D(MAX_COEFS)) u_coef_re (
    .clk(clk), .we(coef_we), .waddr(idx_w[CAW-1:0]), .wdata(coef_real),
    .raddr(ci_w[CAW-1:0]), .rdata(cre_rd)
  );

  fspe_ram #(.W(WORD_W), .D(MAX_COEFS)) u_coef_im (
    .clk(clk), .we(coef_we), .waddr(idx_w[CAW-1:0]), .wdata(coef_imag),
    .raddr(ci_w[CAW-1:0]), .rdata(cim_rd)
  );

  for (genvar a = 0; a < 3; a++) begin : g_wave
    assign wave_we[a] = cmd.load_wave && (idx_w < MAX_TABLE) && (axis_sel == 2'(a));

    fspe_ram #(.W(WORD_W), .D(MAX_TABLE)) u_wave (
      .clk(clk), .we(wave_we[a]), .waddr(idx_w[TAW-1:0]), .wdata(wave_value),
      .raddr(tidx[a][TAW-1:0]), .rdata(wave_rd[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], cmd.issue};
    end
  end

  assign mhi_full = phs_r[63:32] * INV_TWO_PI;
  assign mlo_full = phs_r[31:0] * INV_TWO_PI;
  assign flip     = t_r[31] ^ t_r[30];
  assign tz       = flip ? t_r - 32'h8000_0000 : t_r;

  always_ff @(posedge clk) begin
    cok1_r <= cok;
    tok1_r <= tok;
    for (int a = 0; a < 3; a++) begin
      ph_r[a] <= $signed(tok1_r[a] ? wave_rd[a] : '0) * pos_r[a];
    end
    cre_d[0] <= cok1_r ? $signed(cre_rd) : '0;
    cim_d[0] <= cok1_r ? $signed(cim_rd) : '0;
    for (int k = 1; k <= S + 5; k++) begin
      cre_d[k] <= cre_d[k-1];
      cim_d[k] <= cim_d[k-1];
    end
    phs_r <= ph_r[0] + ph_r[1] + ph_r[2];
    // upper word of (phase * 2^32/2pi) mod 2^64, split in two partial products
    mhi_r <= mhi_full[31:0];
    mlo_r <= mlo_full[61:32];
    t_r   <= mhi_r + {2'b00, mlo_r};
    // quadrants II and III: rotate by half a turn, negate afterwards
    cx_r[0]   <= CORDIC_X0;
    cy_r[0]   <= '0;
    cz_r[0]   <= CRD_W'($signed(tz));
    flip_d[0] <= flip;
  end

  for (genvar k = 0; k < S; k++) begin : g_cordic
    localparam logic signed [CRD_W-1:0] Atn = $signed({2'b00, atan_turns(k)});

    always_ff @(posedge clk) begin
      if (!cz_r[k][CRD_W-1]) begin
        cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
        cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
        cz_r[k+1] <= cz_r[k] - Atn;
      end else begin
        cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
        cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
        cz_r[k+1] <= cz_r[k] + Atn;
      end
      flip_d[k+1] <= flip_d[k];
    end
  end

  always_ff @(posedge clk) begin
    cos_r  <= sc_round(cx_r[S], flip_d[S]);
    sin_r  <= sc_round(cy_r[S], flip_d[S]);
    p_rc_r <= cre_d[S+5] * cos_r;
    p_is_r <= cim_d[S+5] * sin_r;
    p_rs_r <= cre_d[S+5] * sin_r;
    p_ic_r <= cim_d[S+5] * cos_r;
    tr_r   <= p_rc_r - p_is_r;
    ti_r   <= p_rs_r + p_ic_r;
  end

  assign sum_re = acc_re_r + tr_r;
  assign sum_im = acc_im_r + ti_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      sat_r    <= 1'b0;
    end else if (vld_r[NST-1]) begin
      if (sum_re[ACC_W] != sum_re[ACC_W-1]) begin
        acc_re_r <= sum_re[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_re_r <= sum_re[ACC_W-1:0];
      end
      if (sum_im[ACC_W] != sum_im[ACC_W-1]) begin
        acc_im_r <= sum_im[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_im_r <= sum_im[ACC_W-1:0];
      end
      sat_r <= sat_r || (sum_re[ACC_W] != sum_re[ACC_W-1]) ||
               (sum_im[ACC_W] != sum_im[ACC_W-1]);
    end
  end

  // Q.41 -> Q24.24, round half up
  assign rnd_re  = ($signed({acc_re_r[ACC_W-1], acc_re_r[ACC_W-1:16]}) + 49'sd1) >>> 1;
  assign rnd_im  = ($signed({acc_im_r[ACC_W-1], acc_im_r[ACC_W-1:16]}) + 49'sd1) >>> 1;
  assign clip_re = rnd_re[OUT_W] != rnd_re[OUT_W-1];
  assign clip_im = rnd_im[OUT_W] != rnd_im[OUT_W-1];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pot_re_r  <= clip_re ? (rnd_re[OUT_W] ? OUT_MIN : OUT_MAX) : rnd_re[OUT_W-1:0];
      pot_im_r  <= clip_im ? (rnd_im[OUT_W] ? OUT_MIN : OUT_MAX) : rnd_im[OUT_W-1:0];
      sat_out_r <= sat_r || clip_re || clip_im;
    end
  end

  assign potential_real = pot_re_r;
  assign potential_imag = pot_im_r;
  assign saturated      = sat_out_r;

endmodule

@@ rtl/fourier_series_point_evaluator_unit.sv @@
// Channel | Dir | Carries
// in_     | in  | load coefficient, load wave entry or evaluate point request
// out_    | out | one complex Q24.24 sum per evaluate request
// cfg_    | in  | harmonic counts and table sizes
//
// Load requests are taken whenever the unit is idle. While an evaluate request
// runs, one term enters the phase/CORDIC/MAC pipeline per cycle, then the
// pipeline drains into the accumulator.
// rst_n is synchronous; stores are not cleared. A held result stalls only
// the next evaluate at its final write; loads are still taken.
`include "fourier_series_point_evaluator_unit_defines.svh"

module fourier_series_point_evaluator_unit #(
  parameter int MAX_PER_AXIS = 16,
  parameter int MAX_TABLE    = 32,
  parameter int MAX_COEFS    = 4096,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // entry_index, coef_real, coef_imag, wave_value, pos_x, pos_y, pos_z, zero pad
  input  logic [fspe_pkg::IN_DATA_W-1:0]       in_tdata,
  // req_type, axis_sel
  input  logic [fspe_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // potential_real, potential_imag
  output logic [fspe_pkg::OUT_DATA_W-1:0]      out_tdata,
  // saturated
  output logic [fspe_pkg::OUT_USER_W-1:0]      out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fspe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fspe_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;
  logic [OUT_W-1:0] pot_re, pot_im;
  logic             sat;

  assign cfg_ready = 1'b1;

  fspe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_req(in_tuser[1:0]), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd), .state(state)
  );

  fspe_datapath #(
    .MAX_PER_AXIS(MAX_PER_AXIS), .MAX_TABLE(MAX_TABLE),
    .MAX_COEFS(MAX_COEFS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .entry_index(in_tdata[11:0]),
    .axis_sel(in_tuser[3:2]),
    .coef_real(in_tdata[43:12]),
    .coef_imag(in_tdata[75:44]),
    .wave_value(in_tdata[107:76]),
    .pos_x(in_tdata[139:108]),
    .pos_y(in_tdata[171:140]),
    .pos_z(in_tdata[203:172]),
    .potential_real(pot_re), .potential_imag(pot_im), .saturated(sat)
  );

  assign out_tdata = {pot_im, pot_re};
  assign out_tuser = sat;

  `FSPE_ASSERT_IMP(a_idle_quiet, clk, rst_n, state == ST_IDLE, !sts.busy, "terms in flight while idle")
  `FSPE_ASSERT_NXT(a_eval_holds, clk, rst_n, in_tvalid && in_tready && in_tuser[1:0] == REQ_EVAL, !in_tready, "request taken during evaluation")
  `FSPE_ASSERT_IMP(a_emit_finish, clk, rst_n, $rose(out_tvalid), $past(state) == ST_FINISH, "result raised outside finish")

endmodule

@@ tb/fspe_checker.sv @@
module fspe_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [fspe_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [fspe_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [fspe_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic [fspe_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [fspe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                errors,
  output int                                sums_pending,
  output int                                sums_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fspe_pkg::*;

  typedef struct {
    logic [47:0] re;
    logic [47:0] im;
    logic        sat;
  } sum_t;

  // arctan(2^-i) in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [18] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F};

  logic signed [31:0] coef_re [4096];
  logic signed [31:0] coef_im [4096];
  logic signed [31:0] wave_tab [3][32];
  logic [4:0] harm_cnt [3];
  logic [5:0] tab_size [3];
  sum_t sum_q[$];

  assign sums_pending = sum_q.size();

  initial begin
    errors = 0;
    sums_checked = 0;
    for (int i = 0; i < 4096; i++) begin
      coef_re[i] = '0;
      coef_im[i] = '0;
    end
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 32; i++) wave_tab[a][i] = '0;
    end
  end

  function automatic void cordic_sincos(input logic [31:0] turns, output longint c,
                                        output longint s);
    logic   flip;
    longint x, y, z, nx;
    flip = (turns[31:30] == 2'b01) || (turns[31:30] == 2'b10);
    if (flip) turns = turns - 32'h80000000;
    z = longint'($signed(turns));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    x = (x + 4096) >>> 13;
    y = (y + 4096) >>> 13;
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x > 131071) ? 131071 : (x < -131072) ? -131072 : x;
    s = (y > 131071) ? 131071 : (y < -131072) ? -131072 : y;
  endfunction

  function automatic longint wave_at(input int axis, input longint idx);
    if (idx < 0 || idx >= 32) return 0;
    return longint'(wave_tab[axis][idx]);
  endfunction

  function automatic longint acc_add(input longint a, input longint b, inout logic sat);
    longint r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat = 1'b1;
      r = a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end
    return r;
  endfunction

  function automatic longint clip48(input longint v, inout logic sat);
    if (v > 64'sd140737488355327) begin
      sat = 1'b1; return 64'sd140737488355327;
    end
    if (v < -64'sd140737488355328) begin
      sat = 1'b1; return -64'sd140737488355328;
    end
    return v;
  endfunction

  function automatic sum_t series_sum(input logic signed [31:0] px, py, pz);
    longint   cn [3];
    longint   base [3];
    longint   acc_r, acc_i, cr, cim, c, s, r, im;
    logic [63:0] phx, phy, phz, prod;
    logic     sat;
    longint   ci;
    sum_t     res;
    for (int a = 0; a < 3; a++) begin
      cn[a] = (harm_cnt[a] > 16) ? 16 : harm_cnt[a];
      base[a] = longint'(tab_size[a] / 2) - cn[a] / 2;
    end
    acc_r = 0; acc_i = 0; sat = 1'b0;
    for (longint gx = 0; gx < cn[0]; gx++) begin
      phx = wave_at(0, base[0] + gx) * longint'(px);
      for (longint gy = 0; gy < cn[1]; gy++) begin
        phy = wave_at(1, base[1] + gy) * longint'(py);
        for (longint gz = 0; gz < cn[2]; gz++) begin
          phz = wave_at(2, base[2] + gz) * longint'(pz);
          prod = (phx + phy + phz) * 64'd683565276;
          ci = gz + cn[2] * gy + cn[1] * cn[2] * gx;
          cr = 0; cim = 0;
          if (ci < 4096) begin
            cr = longint'(coef_re[ci]);
            cim = longint'(coef_im[ci]);
          end
          cordic_sincos(prod[63:32], c, s);
          acc_r = acc_add(acc_r, cr * c - cim * s, sat);
          acc_i = acc_add(acc_i, cr * s + cim * c, sat);
        end
      end
    end
    r = ((acc_r >>> 16) + 1) >>> 1;
    im = ((acc_i >>> 16) + 1) >>> 1;
    r = clip48(r, sat);
    im = clip48(im, sat);
    res.re = r[47:0];
    res.im = im[47:0];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    logic [1:0]  req, axis;
    logic [11:0] idx;
    sum_t        got, want;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        harm_cnt[a] = 5'd1;
        tab_size[a] = 6'd1;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNT_X: harm_cnt[0] = cfg_data[4:0];
          CFG_COUNT_Y: harm_cnt[1] = cfg_data[4:0];
          CFG_COUNT_Z: harm_cnt[2] = cfg_data[4:0];
          CFG_SIZE_X:  tab_size[0] = cfg_data;
          CFG_SIZE_Y:  tab_size[1] = cfg_data;
          CFG_SIZE_Z:  tab_size[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        req = in_tuser[1:0];
        axis = in_tuser[3:2];
        idx = in_tdata[11:0];
        case (req)
          REQ_COEF: begin
            coef_re[idx] = in_tdata[43:12];
            coef_im[idx] = in_tdata[75:44];
          end
          REQ_WAVE: begin
            if (idx < 32) begin
              case (axis)
                AXIS_X: wave_tab[0][idx] = in_tdata[107:76];
                AXIS_Y: wave_tab[1][idx] = in_tdata[107:76];
                AXIS_Z: wave_tab[2][idx] = in_tdata[107:76];
                default: ;
              endcase
            end
          end
          REQ_EVAL:
            sum_q.push_back(series_sum(in_tdata[139:108], in_tdata[171:140],
                                       in_tdata[203:172]));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.re = out_tdata[47:0];
        got.im = out_tdata[95:48];
        got.sat = out_tuser[0];
        if (sum_q.size() == 0) begin
          $error("unexpected result: potential_real %h potential_imag %h", got.re, got.im);
          errors++;
        end else begin
          want = sum_q.pop_front();
          sums_checked++;
          if (got.re !== want.re) begin
            $error("potential_real: expected %h, got %h", want.re, got.re);
            errors++;
          end
          if (got.im !== want.im) begin
            $error("potential_imag: expected %h, got %h", want.im, got.im);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, got.sat);
            errors++;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fspe_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int TARGET_ITEMS = 140;

  logic                    clk, rst_n;
  logic                    in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic [IN_USER_W-1:0]    in_tuser;
  logic                    out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [OUT_USER_W-1:0]   out_tuser;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  int                      errors, sums_pending, sums_checked;

  int  cycles, items, cfg_sets, in_max_gap, out_max_gap;
  bit  wave_ok [3][32];
  bit  coef_ok [4096];
  int  cur_cnt [3];
  int  cur_size [3];

  fourier_series_point_evaluator_unit dut (.*);

  fspe_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[fourier_series_point_evaluator_unit] ERROR");
      $finish;
    end
  end

  // result side: random stall before each result
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_max_gap);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [11:0] idx,
                              input logic [1:0] axis, input logic [31:0] cre, cim,
                              input logic [31:0] wave, px, py, pz);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {axis, req};
    in_tdata <= {4'b0, pz, py, px, wave, cim, cre, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_coef(input int idx);
    send_request(REQ_COEF, idx[11:0], AXIS_X, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    coef_ok[idx] = 1;
    items++;
  endtask

  task automatic load_wave(input int axis, input int idx, input logic [31:0] v);
    send_request(REQ_WAVE, idx[11:0], axis[1:0], $urandom, $urandom, v, $urandom,
                 $urandom, $urandom);
    if (idx < 32 && axis < 3) wave_ok[axis][idx] = 1;
    items++;
  endtask

  function automatic logic [31:0] rand_wave();
    // mostly modest wave numbers so phases stay meaningful
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  // write every table entry and coefficient the next sum will read
  task automatic fill_needed();
    int c [3];
    int b, n;
    for (int a = 0; a < 3; a++) begin
      c[a] = (cur_cnt[a] > 16) ? 16 : cur_cnt[a];
      b = cur_size[a] / 2 - c[a] / 2;
      for (int g = 0; g < c[a]; g++) begin
        if (b + g >= 0 && b + g < 32 && !wave_ok[a][b + g]) load_wave(a, b + g, rand_wave());
      end
    end
    n = c[0] * c[1] * c[2];
    for (int i = 0; i < n; i++) begin
      if (!coef_ok[i]) load_coef(i);
    end
  endtask

  task automatic evaluate(input logic [31:0] px, py, pz);
    fill_needed();
    send_request(REQ_EVAL, 12'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                 px, py, pz);
    items++;
  endtask

  task automatic drain();
    int wait_cycles;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    wait_cycles = 40;
    for (int a = 0; a < 3; a++) wait_cycles += (cur_cnt[a] > 16) ? 16 : cur_cnt[a];
    wait_cycles += 4096;
    repeat (wait_cycles) @(posedge clk);
  endtask

  task automatic set_config(input int cx, cy, cz, sx, sy, sz);
    int vals [6];
    logic [CFG_IDX_W-1:0] regs [6];
    drain();
    vals = '{cx, cy, cz, sx, sy, sz};
    regs = '{CFG_COUNT_X, CFG_COUNT_Y, CFG_COUNT_Z, CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_cnt = '{cx, cy, cz};
    cur_size = '{sx, sy, sz};
    cfg_sets++;
  endtask

  function automatic int rand_count();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return $urandom_range(0, 4);
    if (p < 9) return $urandom_range(5, 16);
    return $urandom_range(17, 31);
  endfunction

  initial begin
    int cx, cy, cz, pick;
    logic [31:0] junk;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_max_gap = 10;
    out_max_gap = 10;
    cur_cnt = '{1, 1, 1};
    cur_size = '{1, 1, 1};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, extreme points, ignored requests
    evaluate(32'h0, 32'h0, 32'h0);
    evaluate(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    evaluate(32'h80000000, 32'h80000000, 32'h80000000);
    load_wave(AXIS_X, 0, 32'h7FFFFFFF);
    load_wave(AXIS_Y, 0, 32'h80000000);
    load_wave(AXIS_Z, 0, 32'hFFFFFFFF);
    send_request(REQ_COEF, 12'd0, AXIS_X, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0);
    evaluate(32'h0001_0000, 32'hFFFF_0000, 32'h7FFFFFFF);
    junk = $urandom;
    send_request(REQ_WAVE, 12'd4095, AXIS_X, junk, junk, junk, junk, junk, junk);
    send_request(REQ_WAVE, 12'd3, 2'd3, junk, junk, junk, junk, junk, junk);
    send_request(2'd3, 12'hFFF, 2'd3, '1, '1, '1, '1, '1, '1);
    load_coef(4095);
    evaluate($urandom, $urandom, $urandom);

    // zero counts, then both ends of the register ranges
    set_config(0, 0, 0, 0, 0, 0);
    evaluate($urandom, $urandom, $urandom);
    set_config(16, 2, 1, 32, 32, 32);
    evaluate($urandom, $urandom, $urandom);
    evaluate(32'h7FFFFFFF, 32'h80000000, 32'h0);
    set_config(31, 2, 1, 63, 63, 63);
    evaluate($urandom, $urandom, $urandom);
    set_config(16, 1, 1, 1, 1, 1);
    evaluate($urandom, $urandom, $urandom);

    // random phases
    while (items < TARGET_ITEMS) begin
      cx = rand_count();
      cy = rand_count();
      cz = rand_count();
      while (((cx > 16 ? 16 : cx) * (cy > 16 ? 16 : cy) * (cz > 16 ? 16 : cz)) > 64) begin
        cy = $urandom_range(0, 2);
        cz = $urandom_range(0, 2);
      end
      in_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
      set_config(cx, cy, cz, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63));
      repeat ($urandom_range(8, 16)) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          evaluate($urandom, $urandom, $urandom);
        end else if (pick < 15) begin
          load_coef($urandom_range(0, 4095));
        end else if (pick < 17) begin
          load_wave($urandom_range(0, 2), $urandom_range(0, 31), rand_wave());
        end else begin
          junk = $urandom;
          case ($urandom_range(0, 2))
            0: send_request(REQ_WAVE, 12'($urandom_range(32, 4095)), 2'($urandom), junk,
                            junk, junk, junk, junk, junk);
            1: send_request(REQ_WAVE, 12'($urandom), 2'd3, junk, junk, junk, junk, junk,
                            junk);
            default: send_request(2'd3, 12'($urandom), 2'($urandom), junk, junk, junk,
                                  junk, junk, junk);
          endcase
        end
      end
    end

    in_tvalid <= 1'b0;
    while (sums_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run covered %0d requests and %0d configurations", items, cfg_sets);
    $display("%0d sums checked, %0d mismatches", sums_checked, errors);
    if (errors == 0 && sums_pending == 0) begin
      $display("[fourier_series_point_evaluator_unit] OK");
    end else begin
      $display("[fourier_series_point_evaluator_unit] ERROR");
    end
    $finish;
  end
endmodule
